// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros, clocked on the rising edge and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define PFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define PFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define PFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/core/pfd_pkg.sv =====
`default_nettype none

package pfd_pkg;

  localparam int DepthDefault = 64;
  localparam int LimitW       = 7;
  localparam int CountW       = 7;
  localparam logic [LimitW-1:0] LimitReset = 7'd64;
  localparam logic [CountW-1:0] CountMax   = 7'd127;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_FWD = 2'd1,
    CMD_CNT = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_SUM  = 2'd2,
    S_DONE = 2'd3
  } state_e;

  typedef struct packed {
    logic [31:0] ts;
    logic [15:0] dst;
    logic [15:0] src;
  } entry_t;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] ts;
    logic [15:0] dst;
    logic [15:0] src;
  } key_t;

  typedef struct packed {
    logic shift;
    logic cmp_en;
    logic cmp_add;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfd_cell.sv =====
`default_nettype none

module pfd_cell (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  pfd_pkg::cell_ctrl_t ctrl_i,
  input  wire               wr_sel_i,
  input  wire               occupied_i,
  input  pfd_pkg::key_t     key_i,
  input  pfd_pkg::entry_t   next_i,
  output pfd_pkg::entry_t   entry_o,
  output logic              match_o
);

  pfd_pkg::entry_t entry_q, entry_d;
  logic            match_q, match_d;
  logic            hit_add, hit_cnt;

  always_comb begin
    hit_add = (entry_q.src == key_i.src) && (entry_q.dst == key_i.dst) &&
              (entry_q.ts == key_i.ts);
    hit_cnt = (entry_q.dst == key_i.dst) && (entry_q.ts >= key_i.lo) &&
              (entry_q.ts <= key_i.hi);
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = occupied_i && (ctrl_i.cmp_add ? hit_add : hit_cnt);
    end
    entry_d = entry_q;
    if (wr_sel_i) begin
      entry_d.src = key_i.src;
      entry_d.dst = key_i.dst;
      entry_d.ts  = key_i.ts;
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfd_popcount.sv =====
`default_nettype none

module pfd_popcount #(
  parameter int DEPTH = pfd_pkg::DepthDefault
) (
  input  wire                          clk_i,
  input  wire  [DEPTH-1:0]             match_i,
  output logic [$clog2(DEPTH+1)-1:0]   sum_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LV = $clog2(DEPTH);
  localparam int P  = 1 << LV;

  logic [CW-1:0] lvl0 [P];
  logic [CW-1:0] tree_q [LV:1][P];

  for (genvar n = 0; n < P; n++) begin : g_leaf
    if (n < DEPTH) begin : g_used
      assign lvl0[n] = CW'(match_i[n]);
    end else begin : g_pad
      assign lvl0[n] = '0;
    end
  end

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    for (genvar n = 0; n < P; n++) begin : g_node
      if (n < (P >> l)) begin : g_add
        if (l == 1) begin : g_first
          always_ff @(posedge clk_i) begin
            tree_q[l][n] <= CW'(lvl0[2*n] + lvl0[2*n+1]);
          end
        end else begin : g_upper
          always_ff @(posedge clk_i) begin
            tree_q[l][n] <= CW'(tree_q[l-1][2*n] + tree_q[l-1][2*n+1]);
          end
        end
      end else begin : g_idle
        always_ff @(posedge clk_i) begin
          tree_q[l][n] <= '0;
        end
      end
    end
  end

  assign sum_o = tree_q[LV][0];

endmodule

`default_nettype wire

// ===== rtl/core/packet_fifo_dedup_range_count_core.sv =====
// Packet queue with duplicate filter and range count.
// Input stream: s_axis_tuser carries the command (add, forward, count, no-op),
// s_axis_tdata the packet fields and the time bounds. Output stream: one
// transfer per input transfer on m_axis_tdata, no tlast.
// cfg_we_i/cfg_wdata_i write the queue limit (1..DEPTH after clamping).
// Storage is a row of DEPTH cells; cell 0 holds the oldest packet. A forward
// or an eviction shifts every cell one place toward the head.
// Add and count: every cell compares at once in S_CMP, then a registered adder
// tree of log2(DEPTH) levels sums the hits during S_SUM; the result is loaded
// in S_DONE, and the next item is accepted after the return to S_IDLE.
// Forward and no-op go from S_IDLE straight to S_DONE and load their result there.
// One item is in flight at a time.
// A result waits in the output register; the next item is accepted while it
// waits, and that item stalls in its final cycle until the register frees.
// Reset empties the queue and sets the limit to 64; cell contents are not
// cleared.
`default_nettype none

`include "assert_macros.svh"

module packet_fifo_dedup_range_count_core #(
  parameter int DEPTH = pfd_pkg::DepthDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // source[15:0], destination[31:16], timestamp[63:32], start_time[95:64],
  // end_time[127:96]
  input  wire  [127:0] s_axis_tdata,
  // command[1:0]
  input  wire  [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // accepted[0], packet_valid[1], out_source[17:2], out_destination[33:18],
  // out_timestamp[65:34], match_count[72:66], zero[79:73]
  output logic [79:0]  m_axis_tdata,
  input  wire          cfg_we_i,
  input  wire  [6:0]   cfg_wdata_i
);

  localparam int IW   = $clog2(DEPTH);
  localparam int OW   = $clog2(DEPTH + 1);
  localparam int LV   = $clog2(DEPTH);
  localparam int CNTW = $clog2(LV + 1);
  localparam int LW   = (OW > pfd_pkg::LimitW) ? OW : pfd_pkg::LimitW;
  localparam int SW   = (OW > pfd_pkg::CountW) ? OW : pfd_pkg::CountW;

  pfd_pkg::state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [OW-1:0]   occ_q, occ_d;
  logic [pfd_pkg::LimitW-1:0] lim_q;

  pfd_pkg::cmd_e   cmd_q;
  pfd_pkg::key_t   key_q;

  logic            m_valid_q;
  logic [79:0]     m_data_q, m_data_d;
  logic            out_load;

  pfd_pkg::cell_ctrl_t ctrl;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;

  pfd_pkg::entry_t cell_entry [DEPTH];
  logic [DEPTH-1:0] match;
  logic [OW-1:0]   sum;

  logic [LW-1:0]   lim_eff;
  logic [SW-1:0]   sum_ext;
  logic [pfd_pkg::CountW-1:0] count_sat;
  logic            dup;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    pfd_pkg::entry_t nxt;
    if (k < DEPTH - 1) begin : g_mid
      assign nxt = cell_entry[k+1];
    end else begin : g_end
      assign nxt = '0;
    end
    pfd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_sel_i   (wr_en && (wr_idx == IW'(k))),
      .occupied_i (occ_q > OW'(k)),
      .key_i      (key_q),
      .next_i     (nxt),
      .entry_o    (cell_entry[k]),
      .match_o    (match[k])
    );
  end

  pfd_popcount #(
    .DEPTH (DEPTH)
  ) u_popcount (
    .clk_i   (clk_i),
    .match_i (match),
    .sum_o   (sum)
  );

  always_comb begin
    lim_eff = LW'(lim_q);
    if (lim_eff == '0) begin
      lim_eff = LW'(1);
    end else if (lim_eff > LW'(DEPTH)) begin
      lim_eff = LW'(DEPTH);
    end
    sum_ext   = SW'(sum);
    count_sat = (sum_ext > SW'(pfd_pkg::CountMax)) ? pfd_pkg::CountMax
                                                    : pfd_pkg::CountW'(sum_ext);
    dup       = (sum != '0);
  end

  assign s_axis_tready = (state_q == pfd_pkg::S_IDLE);
  assign out_load      = (state_q == pfd_pkg::S_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    occ_d        = occ_q;
    ctrl.shift   = 1'b0;
    ctrl.cmp_en  = 1'b0;
    ctrl.cmp_add = (cmd_q == pfd_pkg::CMD_ADD);
    wr_en        = 1'b0;
    wr_idx       = '0;
    m_data_d     = '0;
    unique case (state_q)
      pfd_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          if ((s_axis_tuser == pfd_pkg::CMD_ADD) || (s_axis_tuser == pfd_pkg::CMD_CNT)) begin
            state_d = pfd_pkg::S_CMP;
          end else begin
            state_d = pfd_pkg::S_DONE;
          end
        end
      end
      pfd_pkg::S_CMP: begin
        ctrl.cmp_en = 1'b1;
        cnt_d       = '0;
        state_d     = pfd_pkg::S_SUM;
      end
      pfd_pkg::S_SUM: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(LV - 1)) begin
          state_d = pfd_pkg::S_DONE;
        end
      end
      pfd_pkg::S_DONE: begin
        unique case (cmd_q)
          pfd_pkg::CMD_ADD: begin
            m_data_d[0] = !dup;
            if (out_load && !dup) begin
              wr_en = 1'b1;
              if (LW'(occ_q) >= lim_eff) begin
                ctrl.shift = 1'b1;
                wr_idx     = IW'(occ_q - OW'(1));
              end else begin
                wr_idx = IW'(occ_q);
                occ_d  = occ_q + OW'(1);
              end
            end
          end
          pfd_pkg::CMD_FWD: begin
            if (occ_q != '0) begin
              m_data_d[1]     = 1'b1;
              m_data_d[17:2]  = cell_entry[0].src;
              m_data_d[33:18] = cell_entry[0].dst;
              m_data_d[65:34] = cell_entry[0].ts;
              if (out_load) begin
                ctrl.shift = 1'b1;
                occ_d      = occ_q - OW'(1);
              end
            end
          end
          pfd_pkg::CMD_CNT: begin
            m_data_d[72:66] = count_sat;
          end
          pfd_pkg::CMD_NOP: begin
            m_data_d = '0;
          end
        endcase
        if (out_load) begin
          state_d = pfd_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfd_pkg::S_IDLE;
      cnt_q     <= '0;
      occ_q     <= '0;
      lim_q     <= pfd_pkg::LimitReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      occ_q   <= occ_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= pfd_pkg::cmd_e'(s_axis_tuser);
      key_q.src <= s_axis_tdata[15:0];
      key_q.dst <= s_axis_tdata[31:16];
      key_q.ts  <= s_axis_tdata[63:32];
      key_q.lo  <= s_axis_tdata[95:64];
      key_q.hi  <= s_axis_tdata[127:96];
    end
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `PFD_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= OW'(DEPTH))
  `PFD_ASSERT_NEXT(a_occ_only_done, clk_i, rst_ni, state_q != pfd_pkg::S_DONE, $stable(occ_q))
  `PFD_ASSERT_IMPL(a_load_from_done, clk_i, rst_ni, $rose(m_valid_q),
                   $past(state_q) == pfd_pkg::S_DONE)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int Depth         = pfd_pkg::DepthDefault;
  localparam int SettleCycles  = 16;
  localparam int StallLimit    = 2000;
  localparam int SegItems      = 165;
  localparam int NumSegs       = 8;

  typedef struct packed {
    logic [6:0]  zero;
    logic [6:0]  match_count;
    logic [31:0] out_timestamp;
    logic [15:0] out_destination;
    logic [15:0] out_source;
    logic        packet_valid;
    logic        accepted;
  } reply_t;

  class packet_queue_predictor;
    logic [15:0] src_mem [Depth];
    logic [15:0] dst_mem [Depth];
    logic [31:0] ts_mem  [Depth];
    int          head;
    int          occ;
    logic [6:0]  limit;
    reply_t      expected_q[$];
    int          errors;
    int          n_items, n_stored, n_dups, n_fwds, n_empty, n_counts, n_hits;

    function new();
      head  = 0;
      occ   = 0;
      limit = pfd_pkg::LimitReset;
    endfunction

    function int slot(int off);
      return (head + off) % Depth;
    endfunction

    function void note_request(pfd_pkg::cmd_e c, pfd_pkg::key_t k);
      reply_t r;
      int     lim;
      int     s;
      int     hits;
      bit     dup;
      r = '0;
      lim = (limit < 1) ? 1 : ((limit > Depth) ? Depth : int'(limit));
      n_items++;
      case (c)
        pfd_pkg::CMD_ADD: begin
          dup = 1'b0;
          for (int i = 0; i < occ; i++) begin
            s = slot(i);
            if (src_mem[s] == k.src && dst_mem[s] == k.dst && ts_mem[s] == k.ts) dup = 1'b1;
          end
          if (!dup) begin
            if (occ >= lim) begin
              head = slot(1);
              occ--;
            end
            s = slot(occ);
            src_mem[s] = k.src;
            dst_mem[s] = k.dst;
            ts_mem[s]  = k.ts;
            occ++;
            r.accepted = 1'b1;
            n_stored++;
          end else begin
            n_dups++;
          end
        end
        pfd_pkg::CMD_FWD: begin
          n_fwds++;
          if (occ != 0) begin
            r.packet_valid    = 1'b1;
            r.out_source      = src_mem[head];
            r.out_destination = dst_mem[head];
            r.out_timestamp   = ts_mem[head];
            head = slot(1);
            occ--;
          end else begin
            n_empty++;
          end
        end
        pfd_pkg::CMD_CNT: begin
          hits = 0;
          for (int i = 0; i < occ; i++) begin
            s = slot(i);
            if (dst_mem[s] == k.dst && ts_mem[s] >= k.lo && ts_mem[s] <= k.hi) hits++;
          end
          if (hits > int'(pfd_pkg::CountMax)) hits = int'(pfd_pkg::CountMax);
          r.match_count = hits[6:0];
          n_counts++;
          if (hits != 0) n_hits++;
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [79:0] data);
      reply_t got;
      reply_t want;
      got = data;
      if (expected_q.size() == 0) begin
        $error("unexpected output transfer 0x%0h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("accepted", 32'(want.accepted), 32'(got.accepted));
      check_field("packet_valid", 32'(want.packet_valid), 32'(got.packet_valid));
      check_field("out_source", 32'(want.out_source), 32'(got.out_source));
      check_field("out_destination", 32'(want.out_destination),
                  32'(got.out_destination));
      check_field("out_timestamp", want.out_timestamp, got.out_timestamp);
      check_field("match_count", 32'(want.match_count), 32'(got.match_count));
      check_field("zero", 32'(want.zero), 32'(got.zero));
    endfunction
  endclass

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata  = '0;
  logic [1:0]    s_axis_tuser  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [79:0]   m_axis_tdata;
  logic          cfg_we_i      = 1'b0;
  logic [6:0]    cfg_wdata_i   = '0;

  packet_queue_predictor sb = new();
  pfd_pkg::entry_t recent_keys[$];
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     idle_cycles    = 0;

  packet_fifo_dedup_range_count_core #(
    .DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("packet_fifo_dedup_range_count_core regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic pfd_pkg::key_t mk(logic [15:0] src, logic [15:0] dst, logic [31:0] ts,
                                       logic [31:0] lo, logic [31:0] hi);
    pfd_pkg::key_t k;
    k.src = src;
    k.dst = dst;
    k.ts  = ts;
    k.lo  = lo;
    k.hi  = hi;
    return k;
  endfunction

  function automatic pfd_pkg::cmd_e rand_cmd();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 52) return pfd_pkg::CMD_ADD;
    if (p < 73) return pfd_pkg::CMD_FWD;
    if (p < 95) return pfd_pkg::CMD_CNT;
    return pfd_pkg::CMD_NOP;
  endfunction

  function automatic pfd_pkg::key_t rand_key();
    pfd_pkg::key_t   k;
    pfd_pkg::entry_t e;
    int unsigned     sel;
    sel = $urandom_range(99);
    k = mk(16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
    if (sel < 50) begin
      k.src = 16'($urandom_range(3));
      k.dst = 16'($urandom_range(3));
      k.ts  = $urandom_range(7);
      k.lo  = $urandom_range(7);
      k.hi  = $urandom_range(7);
    end else if (sel < 78 && recent_keys.size() != 0) begin
      e = recent_keys[$urandom_range(recent_keys.size() - 1)];
      k.src = e.src;
      k.dst = e.dst;
      k.ts  = e.ts;
      k.lo  = e.ts - $urandom_range(3);
      k.hi  = e.ts + $urandom_range(3);
    end
    return k;
  endfunction

  task automatic send_req(pfd_pkg::cmd_e c, pfd_pkg::key_t k);
    pfd_pkg::entry_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= k;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(c, k);
    if (c == pfd_pkg::CMD_ADD) begin
      e.src = k.src;
      e.dst = k.dst;
      e.ts  = k.ts;
      recent_keys = {recent_keys, e};
      if (recent_keys.size() > 16) void'(recent_keys.pop_front());
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [6:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.limit = value;
  endtask

  initial begin
    logic [6:0] seg_limit [NumSegs];
    seg_limit = '{7'd127, 7'd0, 7'd64, 7'd1, 7'd5, 7'd0, 7'd33, 7'd64};
    seg_limit[5] = 7'($urandom_range(63, 2));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(pfd_pkg::CMD_FWD, mk('0, '0, '0, '0, '0));
    send_req(pfd_pkg::CMD_CNT, mk('0, '0, '0, '0, '1));
    send_req(pfd_pkg::CMD_NOP, mk('1, '1, '1, '1, '1));
    send_req(pfd_pkg::CMD_ADD, mk('0, '0, '0, '0, '0));
    send_req(pfd_pkg::CMD_ADD, mk('1, '1, '1, '1, '1));
    send_req(pfd_pkg::CMD_ADD, mk('0, '0, '0, '1, '1));
    send_req(pfd_pkg::CMD_CNT, mk('0, '1, '0, '0, '1));
    send_req(pfd_pkg::CMD_CNT, mk('0, '0, '0, 32'd5, '0));
    send_req(pfd_pkg::CMD_CNT, mk('0, '0, '0, '0, '0));
    send_req(pfd_pkg::CMD_NOP, mk('0, '0, '0, '0, '0));
    send_req(pfd_pkg::CMD_FWD, mk('0, '0, '0, '0, '0));
    set_limit(7'd2);
    send_req(pfd_pkg::CMD_ADD, mk(16'h1234, 16'h0001, 32'h10, '0, '0));
    send_req(pfd_pkg::CMD_ADD, mk('1, '1, '1, '0, '0));
    send_req(pfd_pkg::CMD_ADD, mk(16'h1234, 16'h0001, 32'h11, '0, '0));
    send_req(pfd_pkg::CMD_CNT, mk('0, 16'h0001, '0, 32'h10, 32'h11));
    set_limit(7'd1);
    send_req(pfd_pkg::CMD_ADD, mk(16'h0005, 16'h0001, 32'h12, '0, '0));
    send_req(pfd_pkg::CMD_CNT, mk('0, 16'h0001, '0, '0, '1));
    repeat (3) send_req(pfd_pkg::CMD_FWD, mk('0, '0, '0, '0, '0));

    for (int seg = 0; seg < NumSegs; seg++) begin
      set_limit(seg_limit[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < SegItems; n++) send_req(rand_cmd(), rand_key());
    end

    wait_drained();
    $display("run covered %0d transfers over %0d limit settings incl. 0, 1, 64 and 127",
             sb.n_items, NumSegs + 2);
    $display("stored %0d, duplicates %0d, forwards %0d (%0d empty), counts %0d (%0d nonzero)",
             sb.n_stored, sb.n_dups, sb.n_fwds, sb.n_empty, sb.n_counts, sb.n_hits);
    if (sb.errors == 0) begin
      $display("packet_fifo_dedup_range_count_core regression: pass");
    end else begin
      $display("packet_fifo_dedup_range_count_core regression: fail");
    end
    $finish;
  end

endmodule
